[rtl/imuq_pkg.sv]
// Shared constants, types and helper functions of the IMU feature quantizer.
`timescale 1ns / 1ps
`default_nettype none
package imuq_pkg;

  // Input field widths (defaults for the top-level parameters)
  localparam int ACCEL_BITS_DEF = 18;
  localparam int GYRO_BITS_DEF  = 17;

  // Clamp limits and magnitude widths
  localparam int ACC_MAG_W = 17;
  localparam int GYR_MAG_W = 14;
  localparam logic [ACC_MAG_W-1:0] ACC_LIM = 17'd65536;   // 8 g
  localparam logic [GYR_MAG_W-1:0] GYR_LIM = 14'd16000;   // 500 dps

  // Gyro magnitude: sum of squares and root
  localparam int SUM_W  = 30;
  localparam logic [SUM_W-1:0] SUM_SAT = 30'd256000000;   // GYR_LIM squared
  localparam int RAD_W  = 28;
  localparam int ROOT_W = 14;
  localparam int REM_W  = 15;
  localparam int SQ_PER_STG = 4;
  localparam int SQ_STAGES  = (ROOT_W + SQ_PER_STG - 1) / SQ_PER_STG;

  // Scaling
  localparam int INV_W  = 24;
  localparam int R_W    = 9;                               // rounded magnitude, max 256
  localparam int ACC_P_W = ACC_MAG_W + INV_W;
  localparam int GYR_P_W = GYR_MAG_W + INV_W;
  localparam logic [ACC_P_W:0] ACC_RND = 42'h0_8000_0000; // half of 2^32
  localparam logic [GYR_P_W:0] GYR_RND = 39'd524288000;   // half of 16000 * 2^16
  localparam int GYR_SH  = 23;                             // 16000 * 2^16 = 125 * 2^23
  localparam int U_W     = 15;
  localparam int RCP_W   = 18;
  localparam logic [RCP_W-1:0] GYR_RCP = 18'd134217;      // floor(2^24 / 125)
  localparam int RCP_SH  = 24;
  localparam logic [U_W:0] GYR_DIV = 16'd125;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_AXIS_MODE  = 2'd0;
  localparam logic [1:0] REG_INV_SCALE  = 2'd1;
  localparam logic [1:0] REG_ZP_OFS     = 2'd2;
  localparam logic MODE_SIX  = 1'b0;
  localparam logic MODE_FOUR = 1'b1;
  localparam logic [INV_W-1:0] INV_SCALE_RST = 24'h800000;
  localparam logic [2:0] CNT_SIX  = 3'd6;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  // Clamped per-axis magnitudes and signs
  typedef struct packed {
    logic [2:0][ACC_MAG_W-1:0] acc_mag;
    logic [2:0]                acc_neg;
    logic [2:0][GYR_MAG_W-1:0] gyr_mag;
    logic [2:0]                gyr_neg;
  } imuq_axes_t;

  // Square-root working set
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
  } imuq_sq_t;

  // One restoring root step: bring down two radicand bits, trial subtract.
  function automatic imuq_sq_t sq_step(input imuq_sq_t x);
    imuq_sq_t             y;
    logic [REM_W+1:0]     rem_sh;
    logic [ROOT_W+1:0]    trial;
    y      = x;
    rem_sh = {x.rem, x.rad[RAD_W-1 -: 2]};
    trial  = {x.root, 2'b01};
    y.rad  = {x.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= {1'b0, trial}) begin
      y.rem  = REM_W'(rem_sh - {1'b0, trial});
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = rem_sh[REM_W-1:0];
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  // Apply sign, add zero point, saturate to int8.
  function automatic logic signed [7:0] sat_feature(input logic neg,
                                                    input logic [R_W-1:0] r,
                                                    input logic signed [7:0] zp);
    logic signed [10:0] rs;
    logic signed [10:0] s;
    rs = $signed({2'b00, r});
    s  = neg ? (11'(zp) - rs) : (11'(zp) + rs);
    if (s > 11'sd127) begin
      return 8'sd127;
    end else if (s < -11'sd128) begin
      return -8'sd128;
    end else begin
      return 8'(s);
    end
  endfunction

endpackage
`default_nettype wire

[rtl/imu_feature_int8_quantizer_core.sv]
// Top level of the IMU feature int8 quantizer: register port, pipeline, output stage.
`timescale 1ns / 1ps
`default_nettype none
// Takes one six-axis IMU sample per clock (start high; busy is always low) and
// returns one beat of six int8 features plus a feature count, marked by out_valid.
// The throughput is one sample per cycle; the latency is set by the gyro magnitude
// path: three input stages (clamp, squares, sum), the pipelined square root
// (up to four root bits per stage, four stages), four stages of gyro scaling and
// rounded division, and the output register. The receiver cannot stall: every
// out_valid beat must be taken in that cycle. Registers (APB, byte address 4*i):
// 0 axis_mode, 1 inv_scale (Q8.16), 2 zero-point offset; write them only while no
// sample is in flight. In four-axis mode feature_3 carries the gyro magnitude
// and features 4 and 5 read zero.
module imu_feature_int8_quantizer_core #(
  parameter int ACCEL_BITS = imuq_pkg::ACCEL_BITS_DEF,
  parameter int GYRO_BITS  = imuq_pkg::GYRO_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // APB register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [imuq_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // sample in
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ACCEL_BITS-1:0]    in_accel_x,
  input  logic signed [ACCEL_BITS-1:0]    in_accel_y,
  input  logic signed [ACCEL_BITS-1:0]    in_accel_z,
  input  logic signed [GYRO_BITS-1:0]     in_gyro_x,
  input  logic signed [GYRO_BITS-1:0]     in_gyro_y,
  input  logic signed [GYRO_BITS-1:0]     in_gyro_z,
  // features out
  output logic                            out_valid,
  output logic signed [7:0]               out_feature_0,
  output logic signed [7:0]               out_feature_1,
  output logic signed [7:0]               out_feature_2,
  output logic signed [7:0]               out_feature_3,
  output logic signed [7:0]               out_feature_4,
  output logic signed [7:0]               out_feature_5,
  output logic [2:0]                      out_feature_count
);
  import imuq_pkg::*;

  localparam int DLY = SQ_STAGES + 2;   // axis delay taps
  localparam int LAT = SQ_STAGES + 8;   // start to out_valid

  // ---------------- configuration registers ----------------
  logic              axis_mode_r;
  logic [INV_W-1:0]  inv_scale_r;
  logic signed [7:0] zp_ofs_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];   // byte offsets within a word are ignored

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_mode_r  <= MODE_SIX;
      inv_scale_r  <= INV_SCALE_RST;
      zp_ofs_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AXIS_MODE:  axis_mode_r  <= pwdata[0];
        REG_INV_SCALE:  inv_scale_r  <= pwdata[INV_W-1:0];
        REG_ZP_OFS:     zp_ofs_r     <= $signed(pwdata[7:0]);
        default: ;      // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AXIS_MODE:  prdata = {31'b0, axis_mode_r};
      REG_INV_SCALE:  prdata = {{(32-INV_W){1'b0}}, inv_scale_r};
      REG_ZP_OFS:     prdata = {24'b0, zp_ofs_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------- input conditioning ----------------
  // Fully pipelined: a new sample every cycle.
  assign busy = 1'b0;

  logic                      fr_vld;
  imuq_axes_t                fr_axes;
  logic [RAD_W-1:0]          fr_rad;
  logic                      fr_sat;

  imuq_front #(
    .ACCEL_BITS (ACCEL_BITS),
    .GYRO_BITS  (GYRO_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start && !busy),
    .acc_i  ({in_accel_z, in_accel_y, in_accel_x}),
    .gyr_i  ({in_gyro_z, in_gyro_y, in_gyro_x}),
    .vld_o  (fr_vld),
    .axes_o (fr_axes),
    .rad_o  (fr_rad),
    .sat_o  (fr_sat)
  );

  // ---------------- gyro magnitude root ----------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_sat;

  imuq_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (fr_vld),
    .rad_i  (fr_rad),
    .sat_i  (fr_sat),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sat_o  (sq_sat)
  );

  // Axis magnitudes ride alongside the root. Tap SQ_STAGES-1 lines up with the
  // root output; the last tap feeds the shorter accel lanes.
  imuq_axes_t     dly_r [DLY];
  logic [DLY-1:0] dly_vld_r;

  always_ff @(posedge clk) begin
    dly_r[0] <= fr_axes;
    for (int k = 1; k < DLY; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else begin
      dly_vld_r <= {dly_vld_r[DLY-2:0], fr_vld};
    end
  end

  // ---------------- scaling lanes ----------------
  logic [GYR_MAG_W-1:0] g_mag [3];
  logic [2:0]           g_neg;
  logic [2:0]           gyr_vld;
  logic [R_W-1:0]       gyr_r [3];
  logic [2:0]           gyr_neg;
  logic [2:0]           acc_vld;
  logic [R_W-1:0]       acc_r [3];
  logic [2:0]           acc_neg;

  // gyro lane 0 (feature 3) carries the clamped magnitude in four-axis mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_mag[i] = dly_r[SQ_STAGES-1].gyr_mag[i];
      g_neg[i] = dly_r[SQ_STAGES-1].gyr_neg[i];
    end
    if (axis_mode_r == MODE_FOUR) begin
      g_mag[0] = sq_sat ? GYR_LIM : sq_root;
      g_neg[0] = 1'b0;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    imuq_gyr_scale u_gyr (
      .clk         (clk),
      .rst_n       (rst_n),
      .vld_i       (sq_vld),
      .mag_i       (g_mag[i]),
      .neg_i       (g_neg[i]),
      .inv_scale_i (inv_scale_r),
      .vld_o       (gyr_vld[i]),
      .r_o         (gyr_r[i]),
      .neg_o       (gyr_neg[i])
    );

    imuq_acc_scale u_acc (
      .clk         (clk),
      .rst_n       (rst_n),
      .vld_i       (dly_vld_r[DLY-1]),
      .mag_i       (dly_r[DLY-1].acc_mag[i]),
      .neg_i       (dly_r[DLY-1].acc_neg[i]),
      .inv_scale_i (inv_scale_r),
      .vld_o       (acc_vld[i]),
      .r_o         (acc_r[i]),
      .neg_o       (acc_neg[i])
    );
  end

  // ---------------- output stage: sign, zero point, saturate ----------------
  logic signed [7:0] feat_r [6];
  logic [2:0]        cnt_r;
  logic              out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= gyr_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      feat_r[i] <= sat_feature(acc_neg[i], acc_r[i], zp_ofs_r);
    end
    feat_r[3] <= sat_feature(gyr_neg[0], gyr_r[0], zp_ofs_r);
    if (axis_mode_r == MODE_FOUR) begin
      feat_r[4] <= '0;
      feat_r[5] <= '0;
      cnt_r     <= CNT_FOUR;
    end else begin
      feat_r[4] <= sat_feature(gyr_neg[1], gyr_r[1], zp_ofs_r);
      feat_r[5] <= sat_feature(gyr_neg[2], gyr_r[2], zp_ofs_r);
      cnt_r     <= CNT_SIX;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_feature_0     = feat_r[0];
  assign out_feature_1     = feat_r[1];
  assign out_feature_2     = feat_r[2];
  assign out_feature_3     = feat_r[3];
  assign out_feature_4     = feat_r[4];
  assign out_feature_5     = feat_r[5];
  assign out_feature_count = cnt_r;

  // ---------------- assertions ----------------
  // accel and gyro lanes must deliver the same beat together
  a_lane_align: assert property (@(posedge clk) disable iff (!rst_n)
    acc_vld == gyr_vld)
    else $error("accel and gyro lanes out of step");

  // every output beat traces back to an accepted input sample
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("output beat without a matching input beat");

  // root stage valid follows the front end by the root depth
  a_root_vld: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld |-> $past(fr_vld, SQ_STAGES))
    else $error("root pipeline valid out of step");

endmodule
`default_nettype wire

[rtl/imuq_front.sv]
// Input conditioning: clamp and magnitude of all axes, gyro sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module imuq_front #(
  parameter int ACCEL_BITS = imuq_pkg::ACCEL_BITS_DEF,
  parameter int GYRO_BITS  = imuq_pkg::GYRO_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  vld_i,
  input  logic [2:0][ACCEL_BITS-1:0]            acc_i,
  input  logic [2:0][GYRO_BITS-1:0]             gyr_i,
  output logic                                  vld_o,
  output imuq_pkg::imuq_axes_t                  axes_o,
  output logic [imuq_pkg::RAD_W-1:0]            rad_o,
  output logic                                  sat_o
);
  import imuq_pkg::*;

  localparam int AXW = ((ACCEL_BITS > ACC_MAG_W) ? ACCEL_BITS : ACC_MAG_W) + 1;
  localparam int GXW = ((GYRO_BITS > GYR_MAG_W) ? GYRO_BITS : GYR_MAG_W) + 1;

  logic [2:0][ACC_MAG_W-1:0] acc_mag_nxt;
  logic [2:0]                acc_neg_nxt;
  logic [2:0][GYR_MAG_W-1:0] gyr_mag_nxt;
  logic [2:0]                gyr_neg_nxt;

  imuq_axes_t axes1_r, axes2_r, axes3_r;
  logic       vld1_r, vld2_r, vld3_r;
  logic [2:0][2*GYR_MAG_W-1:0] sq2_r;
  logic [RAD_W-1:0] rad3_r;
  logic             sat3_r;
  logic [SUM_W-1:0] sum_nxt;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [AXW-1:0] a_ext;
    logic [AXW-1:0]        a_abs;
    logic signed [GXW-1:0] g_ext;
    logic [GXW-1:0]        g_abs;

    assign a_ext = AXW'($signed(acc_i[i]));
    assign a_abs = a_ext[AXW-1] ? AXW'(-a_ext) : AXW'(a_ext);
    assign acc_neg_nxt[i] = a_ext[AXW-1];
    assign acc_mag_nxt[i] = (a_abs > AXW'(ACC_LIM)) ? ACC_LIM : a_abs[ACC_MAG_W-1:0];

    assign g_ext = GXW'($signed(gyr_i[i]));
    assign g_abs = g_ext[GXW-1] ? GXW'(-g_ext) : GXW'(g_ext);
    assign gyr_neg_nxt[i] = g_ext[GXW-1];
    // a clamped axis already forces the magnitude to or past the limit
    assign gyr_mag_nxt[i] = (g_abs > GXW'(GYR_LIM)) ? GYR_LIM : g_abs[GYR_MAG_W-1:0];
  end

  assign sum_nxt = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    axes1_r <= '{acc_mag: acc_mag_nxt, acc_neg: acc_neg_nxt,
                 gyr_mag: gyr_mag_nxt, gyr_neg: gyr_neg_nxt};
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= (2*GYR_MAG_W)'(axes1_r.gyr_mag[i]) * (2*GYR_MAG_W)'(axes1_r.gyr_mag[i]);
    end
    axes2_r <= axes1_r;
    axes3_r <= axes2_r;
    rad3_r  <= sum_nxt[RAD_W-1:0];
    sat3_r  <= (sum_nxt >= SUM_SAT);
  end

  assign vld_o  = vld3_r;
  assign axes_o = axes3_r;
  assign rad_o  = rad3_r;
  assign sat_o  = sat3_r;

endmodule
`default_nettype wire

[rtl/imuq_isqrt.sv]
// Pipelined restoring integer square root of the gyro sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module imuq_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  input  logic [imuq_pkg::RAD_W-1:0]      rad_i,
  input  logic                            sat_i,
  output logic                            vld_o,
  output logic [imuq_pkg::ROOT_W-1:0]     root_o,
  output logic                            sat_o
);
  import imuq_pkg::*;

  imuq_sq_t             sq_r  [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_r;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stg
    imuq_sq_t stg_in;
    imuq_sq_t stg_nxt;

    if (s == 0) begin : g_head
      assign stg_in = '{rad: rad_i, rem: '0, root: '0, sat: sat_i};
    end else begin : g_body
      assign stg_in = sq_r[s-1];
    end

    always_comb begin
      stg_nxt = stg_in;
      for (int j = 0; j < SQ_PER_STG; j++) begin
        if (s * SQ_PER_STG + j < ROOT_W) begin
          stg_nxt = sq_step(stg_nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      sq_r[s] <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ_STAGES-2:0], vld_i};
    end
  end

  assign vld_o  = vld_r[SQ_STAGES-1];
  assign root_o = sq_r[SQ_STAGES-1].root;
  assign sat_o  = sq_r[SQ_STAGES-1].sat;

endmodule
`default_nettype wire

[rtl/imuq_acc_scale.sv]
// Accel lane: magnitude times reciprocal scale, rounded by 2^32.
`timescale 1ns / 1ps
`default_nettype none
module imuq_acc_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [imuq_pkg::ACC_MAG_W-1:0]   mag_i,
  input  logic                             neg_i,
  input  logic [imuq_pkg::INV_W-1:0]       inv_scale_i,
  output logic                             vld_o,
  output logic [imuq_pkg::R_W-1:0]         r_o,
  output logic                             neg_o
);
  import imuq_pkg::*;

  logic [ACC_P_W-1:0] prod1_r;
  logic               neg1_r, neg2_r;
  logic               vld1_r, vld2_r;
  logic [R_W-1:0]     r2_r;
  logic [ACC_P_W:0]   rnd_nxt;

  assign rnd_nxt = {1'b0, prod1_r} + ACC_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= ACC_P_W'(mag_i) * ACC_P_W'(inv_scale_i);
    neg1_r  <= neg_i;
    r2_r    <= rnd_nxt[32 +: R_W];
    neg2_r  <= neg1_r;
  end

  assign vld_o = vld2_r;
  assign r_o   = r2_r;
  assign neg_o = neg2_r;

endmodule
`default_nettype wire

[rtl/imuq_gyr_scale.sv]
// Gyro lane: magnitude times reciprocal scale, rounded division by 16000 * 2^16.
`timescale 1ns / 1ps
`default_nettype none
module imuq_gyr_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [imuq_pkg::GYR_MAG_W-1:0]   mag_i,
  input  logic                             neg_i,
  input  logic [imuq_pkg::INV_W-1:0]       inv_scale_i,
  output logic                             vld_o,
  output logic [imuq_pkg::R_W-1:0]         r_o,
  output logic                             neg_o
);
  import imuq_pkg::*;

  logic [GYR_P_W-1:0]     prod1_r;
  logic [U_W-1:0]         u2_r, u3_r;
  logic [R_W-1:0]         est3_r, r4_r;
  logic [3:0]             neg_r;
  logic [3:0]             vld_r;
  logic [GYR_P_W:0]       rnd_nxt;
  logic [U_W+RCP_W-1:0]   rcp_nxt;
  logic [U_W:0]           back_nxt;
  logic [U_W:0]           rem_nxt;

  assign rnd_nxt = {1'b0, prod1_r} + GYR_RND;
  // quotient estimate is exact or one low
  assign rcp_nxt  = (U_W+RCP_W)'(u2_r) * (U_W+RCP_W)'(GYR_RCP);
  assign back_nxt = (U_W+1)'(est3_r) * GYR_DIV;
  assign rem_nxt  = (U_W+1)'(u3_r) - back_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= GYR_P_W'(mag_i) * GYR_P_W'(inv_scale_i);
    u2_r    <= rnd_nxt[GYR_SH +: U_W];
    u3_r    <= u2_r;
    est3_r  <= rcp_nxt[RCP_SH +: R_W];
    r4_r    <= (rem_nxt >= GYR_DIV) ? est3_r + R_W'(1) : est3_r;
    neg_r   <= {neg_r[2:0], neg_i};
  end

  assign vld_o = vld_r[3];
  assign r_o   = r4_r;
  assign neg_o = neg_r[3];

endmodule
`default_nettype wire

[test/imuq_feature_check.sv]
// Checker for the IMU feature quantizer: predicts each sample's int8 features and compares.
`timescale 1ns / 1ps
module imuq_feature_check #(
  parameter int ACCEL_BITS = imuq_pkg::ACCEL_BITS_DEF,
  parameter int GYRO_BITS  = imuq_pkg::GYRO_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imuq_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [ACCEL_BITS-1:0]  in_accel_x,
  input  logic signed [ACCEL_BITS-1:0]  in_accel_y,
  input  logic signed [ACCEL_BITS-1:0]  in_accel_z,
  input  logic signed [GYRO_BITS-1:0]   in_gyro_x,
  input  logic signed [GYRO_BITS-1:0]   in_gyro_y,
  input  logic signed [GYRO_BITS-1:0]   in_gyro_z,
  input  logic                          out_valid,
  input  logic signed [7:0]             out_feature_0,
  input  logic signed [7:0]             out_feature_1,
  input  logic signed [7:0]             out_feature_2,
  input  logic signed [7:0]             out_feature_3,
  input  logic signed [7:0]             out_feature_4,
  input  logic signed [7:0]             out_feature_5,
  input  logic [2:0]                    out_feature_count,
  output int                            failures,
  output int                            outstanding,
  output int                            beats_checked
);
  import imuq_pkg::*;

  localparam longint ACC_CLAMP = 65536;                    // 8 g
  localparam longint GYR_CLAMP = 16000;                    // 500 dps
  localparam longint unsigned ACC_DEN = 64'd4294967296;    // 2^32
  localparam longint unsigned GYR_DEN = 64'd1048576000;    // 16000 * 2^16

  typedef struct packed {
    logic [5:0][7:0] feat;
    logic [2:0]      count;
  } feat_beat_t;

  feat_beat_t         feature_q[$];
  logic               mode_r;
  logic [INV_W-1:0]   scale_r;
  logic signed [7:0]  zp_r;

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // floor of the square root, one bit at a time from the top
  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // scale by inv_scale / den, round half away from zero, add zero point, saturate
  function automatic logic [7:0] quantize(input longint v, input longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? -v : v;
    mag = mag * scale_r;
    q = longint'((mag + den / 2) / den);
    if (v < 0) q = -q;
    q = q + zp_r;
    if (q > 127) q = 127;
    else if (q < -128) q = -128;
    return q[7:0];
  endfunction

  function automatic feat_beat_t predict_features(input longint ax, input longint ay,
                                                  input longint az, input longint gx,
                                                  input longint gy, input longint gz);
    feat_beat_t e;
    longint unsigned sq;
    longint unsigned mag;
    e.feat[0] = quantize(clip(ax, ACC_CLAMP), ACC_DEN);
    e.feat[1] = quantize(clip(ay, ACC_CLAMP), ACC_DEN);
    e.feat[2] = quantize(clip(az, ACC_CLAMP), ACC_DEN);
    if (mode_r == MODE_SIX) begin
      e.feat[3] = quantize(clip(gx, GYR_CLAMP), GYR_DEN);
      e.feat[4] = quantize(clip(gy, GYR_CLAMP), GYR_DEN);
      e.feat[5] = quantize(clip(gz, GYR_CLAMP), GYR_DEN);
      e.count   = CNT_SIX;
    end else begin
      sq  = gx * gx + gy * gy + gz * gz;
      mag = int_root(sq);
      if (mag > GYR_CLAMP) mag = GYR_CLAMP;
      e.feat[3] = quantize(longint'(mag), GYR_DEN);
      e.feat[4] = '0;
      e.feat[5] = '0;
      e.count   = CNT_FOUR;
    end
    return e;
  endfunction

  always @(posedge clk) begin : watch
    feat_beat_t seen;
    feat_beat_t want;
    if (!rst_n) begin
      mode_r        = MODE_SIX;
      scale_r       = INV_SCALE_RST;
      zp_r          = '0;
      feature_q.delete();
      failures      = 0;
      beats_checked = 0;
      outstanding  <= 0;
    end else begin
      // sample beat: predicted with the settings in force before this edge
      if (start && !busy)
        feature_q.push_back(predict_features(in_accel_x, in_accel_y, in_accel_z,
                                             in_gyro_x, in_gyro_y, in_gyro_z));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_AXIS_MODE:  mode_r  = pwdata[0];
          REG_INV_SCALE:  scale_r = pwdata[INV_W-1:0];
          REG_ZP_OFS:     zp_r    = pwdata[7:0];
          default: ;  // unmapped, no effect
        endcase
      end
      if (out_valid) begin
        seen.feat  = {out_feature_5, out_feature_4, out_feature_3,
                      out_feature_2, out_feature_1, out_feature_0};
        seen.count = out_feature_count;
        if (feature_q.size() == 0) begin
          $error("result beat with no sample outstanding");
          failures++;
        end else begin
          want = feature_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (seen.feat[k] !== want.feat[k]) begin
              $error("feature_%0d: expected %0d, actual %0d", k,
                     $signed(want.feat[k]), $signed(seen.feat[k]));
              failures++;
            end
          end
          if (seen.count !== want.count) begin
            $error("feature_count: expected %0d, actual %0d", want.count, seen.count);
            failures++;
          end
          beats_checked++;
        end
      end
      outstanding <= feature_q.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for the IMU feature quantizer: clock, reset, stimulus, register setup, verdict.
`timescale 1ns / 1ps
module tb;
  import imuq_pkg::*;

  localparam int AW = ACCEL_BITS_DEF;
  localparam int GW = GYRO_BITS_DEF;
  localparam int ACC_CLAMP = 65536;
  localparam int GYR_CLAMP = 16000;
  localparam logic [1:0] REG_SPARE = 2'd3;       // unmapped slot, writes must be dropped
  localparam int PIPE_LAT = SQ_STAGES + 8;       // sample to result beat
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int IDLE_PCT = 24;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy;
  logic signed [AW-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [GW-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic out_valid;
  logic signed [7:0] out_feature_0, out_feature_1, out_feature_2;
  logic signed [7:0] out_feature_3, out_feature_4, out_feature_5;
  logic [2:0] out_feature_count;

  int failures, outstanding, beats_checked;
  int samples_sent;
  int settings_used;

  imu_feature_int8_quantizer_core #(
    .ACCEL_BITS(AW),
    .GYRO_BITS (GW)
  ) i_dut (.*);

  // Watches both channels and the register port; owns all prediction and compare.
  imuq_feature_check #(
    .ACCEL_BITS(AW),
    .GYRO_BITS (GW)
  ) i_chk (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // APB write: setup phase, then access phase until pready, then back to idle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [INV_W-1:0] scale, input int zp);
    reg_write(REG_AXIS_MODE, {31'd0, mode});
    reg_write(REG_INV_SCALE, {8'd0, scale});
    reg_write(REG_ZP_OFS, 32'(zp));
    settings_used++;
  endtask

  // Drop start and wait until every sample in flight has produced its beat.
  // The extra edge lets the checker's count catch up with the last accept.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One sample beat. Random idle cycles go in front of it; start stays high
  // back to back when no idle is drawn.
  task automatic send_sample(input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz,
                             input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    in_accel_x <= ax[AW-1:0];
    in_accel_y <= ay[AW-1:0];
    in_accel_z <= az[AW-1:0];
    in_gyro_x  <= gx[GW-1:0];
    in_gyro_y  <= gy[GW-1:0];
    in_gyro_z  <= gz[GW-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    samples_sent++;
  endtask

  // Axis value: full raw range, in-range, hugging the clamp, or near zero.
  function automatic int rand_axis(input int bits, input int lim);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = $urandom;
        v = (v <<< (32 - bits)) >>> (32 - bits);
      end
      4, 5, 6: v = int'($urandom_range(2 * lim)) - lim;
      7, 8: begin
        v = lim - 4 + int'($urandom_range(8));
        if ($urandom_range(1)) v = -v;
      end
      default: v = int'($urandom_range(600)) - 300;
    endcase
    return v;
  endfunction

  function automatic logic [INV_W-1:0] rand_scale();
    case ($urandom_range(5))
      0: return 24'd1;
      1: return 24'hFFFFFF;
      2: return INV_W'($urandom_range(24'h00FFFF, 1));
      default: return INV_W'($urandom_range(24'hFFFFFF, 24'h010000));
    endcase
  endfunction

  function automatic int rand_zp();
    case ($urandom_range(4))
      0: return -128;
      1: return 127;
      2: return 0;
      default: return int'($urandom_range(255)) - 128;
    endcase
  endfunction

  initial begin
    samples_sent  = 0;
    settings_used = 0;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    in_gyro_x  = '0;
    in_gyro_y  = '0;
    in_gyro_z  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, six-axis: raw extremes, clamp edges, rounding either
    // side of one half (scale 128: accel 256 LSB is exactly half a step).
    send_sample(0, 0, 0, 0, 0, 0, 1);
    send_sample(131071, 131071, 131071, 65535, 65535, 65535, 1);
    send_sample(-131072, -131072, -131072, -65536, -65536, -65536, 1);
    send_sample(65536, -65536, 65537, 16000, -16000, 16001, 1);
    send_sample(-65537, 256, -256, -16001, 62, 63, 1);
    send_sample(255, -255, 512, -63, -62, 125, 1);
    drain();

    // Four-axis: gyro magnitude through the root, incl. clamp and largest squares.
    apply_setting(MODE_FOUR, INV_SCALE_RST, 0);
    send_sample(0, 0, 0, 3, 4, 0, 1);
    send_sample(8192, -8192, 0, 65535, 65535, 65535, 1);
    send_sample(0, 0, 0, -65536, -65536, -65536, 1);
    send_sample(0, 0, 0, 16000, 0, 0, 1);
    send_sample(0, 0, 0, 9238, 9238, 9238, 1);
    send_sample(0, 0, 0, 1, 1, 1, 1);
    send_sample(0, 0, 0, -11313, 11314, 0, 1);
    drain();

    // Scale 0.5: full-scale gyro and accel land exactly on a half step.
    apply_setting(MODE_SIX, 24'd32768, 0);
    send_sample(0, 0, 0, 16000, -16000, 8000, 1);
    send_sample(65536, -65536, 32768, 0, 0, 0, 1);
    drain();

    // Zero scale: every feature collapses to the zero point. The write to the
    // unmapped slot must leave everything as it was.
    apply_setting(MODE_SIX, 24'd0, -77);
    reg_write(REG_SPARE, $urandom);
    send_sample(131071, -131072, 100, 65535, -65536, 5, 1);
    drain();
    apply_setting(MODE_FOUR, 24'd0, -77);
    send_sample(131071, -131072, 100, 65535, -65536, 5, 1);
    drain();

    // Largest scale with zero point at both rails.
    apply_setting(MODE_FOUR, 24'hFFFFFF, 127);
    send_sample(65536, -65536, -1, 16000, 0, 0, 1);
    send_sample(-131072, 1, 0, 1, 0, 0, 1);
    drain();
    apply_setting(MODE_SIX, 24'hFFFFFF, -128);
    send_sample(65536, -65536, 1, 16000, -16000, -1, 1);
    send_sample(-1, 0, 131071, 1, -1, 0, 1);
    drain();

    // Random phases, fresh settings each; alternating mode, one phase with
    // start held back to back the whole way.
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_setting(p[0] ? MODE_FOUR : MODE_SIX, rand_scale(), rand_zp());
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(rand_axis(AW, ACC_CLAMP), rand_axis(AW, ACC_CLAMP),
                    rand_axis(AW, ACC_CLAMP), rand_axis(GW, GYR_CLAMP),
                    rand_axis(GW, GYR_CLAMP), rand_axis(GW, GYR_CLAMP), p != 2);
      drain();
    end

    // Tail: let any stray beat show up past the pipeline depth.
    for (int w = 0; w < 4000 && outstanding != 0; w++) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);

    $display("Sent %0d samples over %0d register settings, six- and four-axis mode,",
             samples_sent, settings_used);
    $display("scales from 0 to full range, zero point at both rails; %0d beats compared",
             beats_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/imuq_pkg.sv
rtl/imuq_front.sv
rtl/imuq_isqrt.sv
rtl/imuq_acc_scale.sv
rtl/imuq_gyr_scale.sv
rtl/imu_feature_int8_quantizer_core.sv
test/imuq_feature_check.sv
test/tb.sv
